FILE: sv/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the glyph bitmap scaler: scale operation
// codes, register indexes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int GBS_MAX_ROW_BYTES = 32;

    // Configuration register indexes
    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_DATA_W      = 2;
    localparam logic [0:0] CFG_SCALE_OP    = 1'd0;
    localparam logic [0:0] CFG_REDUCE_MODE = 1'd1;

    // Scale operation codes
    localparam logic [1:0] OP_HALVE_HEIGHT  = 2'd0;
    localparam logic [1:0] OP_DOUBLE_WIDTH  = 2'd1;
    localparam logic [1:0] OP_DOUBLE_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_PX,
        S_MERGE,
        S_HI,
        S_LO,
        S_RPL_RD,
        S_RPL_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OSEL_PX,
        OSEL_MERGE,
        OSEL_HI,
        OSEL_LO,
        OSEL_RD
    } t_out_sel;

    typedef struct packed {
        logic     capture;
        logic     mem_we;
        logic     rd_en;
        logic     rd_replay;
        logic     emit;
        t_out_sel osel;
        logic     oend;
        logic     adv;
        logic     pos_clr;
        logic     idx_clr;
        logic     idx_inc;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic last_byte;
        logic last_row;
        logic glyph_end;
        logic row_even;
        logic row_pre_last;
        logic one_row;
        logic odd_width;
        logic idx_last;
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/gbs_ctrl.sv
// ----------------------------------------------------------------------------
// gbs_ctrl
// Sequencer for the glyph bitmap scaler: walks one request through decode,
// output byte generation and the row replay for double height.
// ----------------------------------------------------------------------------
module gbs_ctrl
    import gbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_scale_op,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.empty) begin
                    n_state = S_IDLE;
                end else begin
                    case (i_scale_op)
                        OP_HALVE_HEIGHT: begin
                            if (i_status.last_row) begin
                                n_state = i_status.one_row ? S_PX : S_MERGE;
                            end else if (i_status.row_even) begin
                                n_state = S_IDLE;
                            end else begin
                                n_state = S_MERGE;
                            end
                        end
                        OP_DOUBLE_WIDTH:  n_state = S_HI;
                        OP_DOUBLE_HEIGHT: n_state = S_PX;
                        default:          n_state = S_IDLE;
                    endcase
                end
            end
            S_PX: begin
                if (i_status.out_free) begin
                    if (i_scale_op == OP_DOUBLE_HEIGHT && i_status.last_byte) begin
                        n_state = S_RPL_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MERGE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_HI: begin
                if (i_status.out_free) begin
                    n_state = (i_status.last_byte && i_status.odd_width) ? S_IDLE : S_LO;
                end
            end
            S_LO: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RPL_RD: begin
                n_state = S_RPL_EMIT;
            end
            S_RPL_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.idx_last ? S_IDLE : S_RPL_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.osel = OSEL_PX;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DECIDE: begin
                o_cmd.rd_en = 1'b1;
                if (i_status.empty) begin
                    o_cmd.pos_clr = 1'b1;
                end else begin
                    case (i_scale_op)
                        OP_HALVE_HEIGHT: begin
                            if (!i_status.last_row) begin
                                if (i_status.row_even) begin
                                    o_cmd.mem_we = 1'b1;
                                    o_cmd.adv    = 1'b1;
                                end else begin
                                    o_cmd.mem_we = i_status.row_pre_last;
                                end
                            end
                        end
                        OP_DOUBLE_WIDTH: ;
                        OP_DOUBLE_HEIGHT: o_cmd.mem_we = 1'b1;
                        default:          o_cmd.adv    = 1'b1;
                    endcase
                end
            end
            S_PX: begin
                o_cmd.emit = 1'b1;
                o_cmd.osel = OSEL_PX;
                if (i_scale_op == OP_DOUBLE_HEIGHT) begin
                    o_cmd.oend = 1'b0;
                    if (i_status.out_free) begin
                        o_cmd.idx_clr = i_status.last_byte;
                        o_cmd.adv     = !i_status.last_byte;
                    end
                end else begin
                    o_cmd.oend = i_status.glyph_end;
                    o_cmd.adv  = i_status.out_free;
                end
            end
            S_MERGE: begin
                o_cmd.emit = 1'b1;
                o_cmd.osel = OSEL_MERGE;
                o_cmd.oend = i_status.glyph_end;
                o_cmd.adv  = i_status.out_free;
            end
            S_HI: begin
                o_cmd.emit = 1'b1;
                o_cmd.osel = OSEL_HI;
                if (i_status.last_byte && i_status.odd_width) begin
                    // drop the low half of the last byte of an odd-width row
                    o_cmd.oend = i_status.glyph_end;
                    o_cmd.adv  = i_status.out_free;
                end
            end
            S_LO: begin
                o_cmd.emit = 1'b1;
                o_cmd.osel = OSEL_LO;
                o_cmd.oend = i_status.glyph_end;
                o_cmd.adv  = i_status.out_free;
            end
            S_RPL_RD: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_replay = 1'b1;
            end
            S_RPL_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.osel = OSEL_RD;
                o_cmd.oend = i_status.glyph_end && i_status.idx_last;
                if (i_status.out_free) begin
                    o_cmd.adv     = i_status.idx_last;
                    o_cmd.idx_inc = !i_status.idx_last;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: sv/gbs_dp.sv
// ----------------------------------------------------------------------------
// gbs_dp
// Datapath of the glyph bitmap scaler: request capture, glyph position,
// row store, byte merge and spread, and the output register.
// ----------------------------------------------------------------------------
module gbs_dp
    import gbs_pkg::*;
#(
    parameter int MAX_ROW_BYTES = GBS_MAX_ROW_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic [1:0] i_reduce_mode,
    input  logic [7:0] i_pixel_byte,
    input  logic [7:0] i_ink_width,
    input  logic [7:0] i_glyph_rows,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_glyph_end
);

    localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int WBW = $clog2(MAX_ROW_BYTES + 1);
    localparam int CW  = WBW + 1;

    function automatic logic [7:0] spread_nibble(input logic [3:0] n);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            r[2*i +: 2] = {2{n[i]}};
        end
        return r;
    endfunction

    logic [7:0]    r_px;
    logic [7:0]    r_ink;
    logic [7:0]    r_rows;
    logic [AW-1:0] r_col;
    logic [7:0]    r_row;
    logic [AW-1:0] r_idx;
    logic [7:0]    r_mem [MAX_ROW_BYTES];
    logic [7:0]    r_rd;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_end;

    logic [8:0]    w_ink_sum;
    logic [5:0]    w_wb_raw;
    logic [CW-1:0] w_wb;
    logic [CW-1:0] w_col;
    logic [CW-1:0] w_b;
    logic [CW-1:0] w_b_inc;
    logic [8:0]    w_row_inc;
    logic [9:0]    w_dw_sum;
    logic [AW-1:0] w_rd_addr;
    logic          w_out_free;
    logic [7:0]    w_merge;
    logic [7:0]    w_out_byte;

    // Bytes per row, saturated to the store depth
    assign w_ink_sum = {1'b0, r_ink} + 9'd7;
    assign w_wb_raw  = w_ink_sum[8:3];
    assign w_wb      = ({1'b0, w_wb_raw} > 7'(MAX_ROW_BYTES)) ? CW'(MAX_ROW_BYTES)
                                                              : CW'(w_wb_raw);

    // Clamp the column to the current row width
    assign w_col     = CW'(r_col);
    assign w_b       = (w_col >= w_wb) ? (w_wb - CW'(1)) : w_col;
    assign w_b_inc   = w_b + CW'(1);
    assign w_row_inc = {1'b0, r_row} + 9'd1;
    assign w_dw_sum  = {1'b0, r_ink, 1'b0} + 10'd7;

    always_comb begin
        o_status.empty        = (w_wb == '0) || (r_rows == 8'd0);
        o_status.last_byte    = (w_b_inc >= w_wb);
        o_status.last_row     = (w_row_inc >= {1'b0, r_rows});
        o_status.glyph_end    = o_status.last_byte && o_status.last_row;
        o_status.row_even     = !r_row[0];
        o_status.row_pre_last = (({1'b0, r_row} + 9'd2) == {1'b0, r_rows});
        o_status.one_row      = (r_rows == 8'd1);
        o_status.odd_width    = w_dw_sum[3];
        o_status.idx_last     = ((CW'(r_idx) + CW'(1)) == w_wb);
        o_status.out_free     = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px   <= i_pixel_byte;
            r_ink  <= i_ink_width;
            r_rows <= i_glyph_rows;
        end
    end

    // Glyph position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.pos_clr || (i_cmd.adv && o_status.glyph_end)) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.adv && o_status.last_byte) begin
            r_col <= '0;
            r_row <= w_row_inc[7:0];
        end else if (i_cmd.adv) begin
            r_col <= w_b_inc[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // Row store: one write and one registered read per cycle
    assign w_rd_addr = i_cmd.rd_replay ? r_idx : w_b[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[w_b[AW-1:0]] <= r_px;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    assign w_merge = i_reduce_mode[1] ? (r_rd & r_px) : (r_rd | r_px);

    always_comb begin
        case (i_cmd.osel)
            OSEL_PX:    w_out_byte = r_px;
            OSEL_MERGE: w_out_byte = w_merge;
            OSEL_HI:    w_out_byte = spread_nibble(r_px[7:4]);
            OSEL_LO:    w_out_byte = spread_nibble(r_px[3:0]);
            OSEL_RD:    w_out_byte = r_rd;
            default:    w_out_byte = r_px;
        endcase
    end

    // Output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && w_out_free) begin
            r_out_byte <= w_out_byte;
            r_out_end  <= i_cmd.oend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_glyph_end = r_out_end;

endmodule

FILE: sv/glyph_bitmap_scaler_core.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_scaler_core
// Scales 1-bit glyph bitmaps streamed as row-major bytes: halve height,
// double width or double height, selected by a configuration register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one pixel byte per request
//   together with the glyph's ink width and row count. Output channel
//   (o_out_valid / i_out_ready) carries scaled bytes, o_glyph_end marking the
//   last byte of a glyph. Program scale_op and reduce_mode through the write
//   port (i_cfg_we, i_cfg_idx, i_cfg_data) only while the block is idle.
//   One request is processed at a time by the sequencer. A request that only
//   updates the row store emits no byte; o_out_valid is registered. Double
//   width emits two bytes, but only the high-half byte for the last byte of
//   an odd-width row. The last byte of a row in double height replays the row
//   from the store byte by byte (one store read, then one output load). A
//   single output register holds the result; while the receiver stalls the
//   sequencer waits on it, and a new request is taken again once the last
//   byte of the current one has entered the output register.
//   Reset clears the configuration, the glyph position and the output valid;
//   the row store is not cleared, and the user must write it before its
//   contents are used; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module glyph_bitmap_scaler_core
    import gbs_pkg::*;
#(
    parameter int MAX_ROW_BYTES = GBS_MAX_ROW_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input requests
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_pixel_byte,
    input  logic [7:0]            i_ink_width,
    input  logic [7:0]            i_glyph_rows,
    // output requests
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_glyph_end
);

    logic [1:0] r_scale_op;
    logic [1:0] r_reduce_mode;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_op    <= OP_HALVE_HEIGHT;
            r_reduce_mode <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE_OP:    r_scale_op    <= i_cfg_data;
                CFG_REDUCE_MODE: r_reduce_mode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_scale_op (r_scale_op),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    gbs_dp #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_reduce_mode (r_reduce_mode),
        .i_pixel_byte  (i_pixel_byte),
        .i_ink_width   (i_ink_width),
        .i_glyph_rows  (i_glyph_rows),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_glyph_end   (o_glyph_end)
    );

endmodule

FILE: tb/gbs_output_checker.sv
// ----------------------------------------------------------------------------
// gbs_output_checker
// Watches the configuration port and both request channels of the glyph
// bitmap scaler. Predicts the scaled bytes of every accepted pixel byte and
// compares each delivered byte, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gbs_output_checker
    import gbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [7:0]            i_pixel_byte,
    input  logic [7:0]            i_ink_width,
    input  logic [7:0]            i_glyph_rows,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [7:0]            i_out_byte,
    input  logic                  i_glyph_end,
    output int                    o_bytes_due,
    output int                    o_mismatches
);

    typedef struct packed {
        logic [7:0] pixels;
        logic       glyph_end;
    } t_scaled_byte;

    t_scaled_byte scaled_bytes_due[$];

    logic [1:0]  cfg_scale_op;
    logic [1:0]  cfg_reduce_mode;
    logic [7:0]  row_bytes [GBS_MAX_ROW_BYTES];
    int unsigned col_pos;
    int unsigned row_pos;
    int          mismatches = 0;
    t_scaled_byte due;

    initial begin
        o_bytes_due  = 0;
        o_mismatches = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t ns: mismatch on %s: got 0x%02h, want 0x%02h", $time, what, got, want);
    endtask

    function automatic logic [7:0] double_bits(input logic [3:0] n);
        return {n[3], n[3], n[2], n[2], n[1], n[1], n[0], n[0]};
    endfunction

    // reduce_mode bit 1 selects the space merge (AND), else ink merge (OR)
    function automatic logic [7:0] merge_rows(input logic [7:0] a, input logic [7:0] b);
        return cfg_reduce_mode[1] ? (a & b) : (a | b);
    endfunction

    task automatic push_scaled(input logic [7:0] pixels, input logic last);
        scaled_bytes_due.push_back('{pixels: pixels, glyph_end: last});
    endtask

    task automatic predict_scaled_bytes(input logic [7:0] px, input logic [7:0] ink,
                                        input logic [7:0] rows);
        int unsigned wb, b, r, dbl_bytes;
        logic        last_byte, last_row, glyph_done;
        wb = (32'(ink) + 32'd7) >> 3;
        if (wb > GBS_MAX_ROW_BYTES) wb = GBS_MAX_ROW_BYTES;
        if (wb == 0 || rows == 8'd0) begin
            col_pos = 0;
            row_pos = 0;
            return;
        end
        b = (col_pos >= wb) ? wb - 1 : col_pos;
        r = row_pos;
        last_byte  = (b + 1 >= wb);
        last_row   = (r + 1 >= 32'(rows));
        glyph_done = last_byte && last_row;

        case (cfg_scale_op)
            OP_HALVE_HEIGHT: begin
                if (last_row) begin
                    push_scaled((rows == 8'd1) ? px : merge_rows(row_bytes[b], px), glyph_done);
                end else if (r % 2 == 0) begin
                    row_bytes[b] = px;
                end else begin
                    push_scaled(merge_rows(row_bytes[b], px), 1'b0);
                    // keep the middle row of a closing triple
                    if (r + 2 == 32'(rows)) row_bytes[b] = px;
                end
            end
            OP_DOUBLE_WIDTH: begin
                dbl_bytes = ((32'(ink) << 1) + 32'd7) >> 3;
                if (last_byte && dbl_bytes[0]) begin
                    push_scaled(double_bits(px[7:4]), glyph_done);
                end else begin
                    push_scaled(double_bits(px[7:4]), 1'b0);
                    push_scaled(double_bits(px[3:0]), glyph_done);
                end
            end
            OP_DOUBLE_HEIGHT: begin
                row_bytes[b] = px;
                push_scaled(px, 1'b0);
                if (last_byte) begin
                    for (int unsigned k = 0; k < wb; k++)
                        push_scaled(row_bytes[k], glyph_done && (k + 1 == wb));
                end
            end
            default: ;
        endcase

        if (glyph_done) begin
            col_pos = 0;
            row_pos = 0;
        end else if (last_byte) begin
            col_pos = 0;
            row_pos = (r + 1) & 32'hff;
        end else begin
            col_pos = b + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_scale_op    = OP_HALVE_HEIGHT;
            cfg_reduce_mode = '0;
            col_pos         = 0;
            row_pos         = 0;
            scaled_bytes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SCALE_OP:    cfg_scale_op    = i_cfg_data;
                    CFG_REDUCE_MODE: cfg_reduce_mode = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_scaled_bytes(i_pixel_byte, i_ink_width, i_glyph_rows);
            if (i_out_valid && i_out_ready) begin
                if (scaled_bytes_due.size() == 0) begin
                    report_mismatch("output with nothing due", i_out_byte, 0);
                end else begin
                    due = scaled_bytes_due.pop_front();
                    if (i_out_byte !== due.pixels)
                        report_mismatch("out_byte", i_out_byte, due.pixels);
                    if (i_glyph_end !== due.glyph_end)
                        report_mismatch("glyph_end", i_glyph_end, due.glyph_end);
                end
            end
        end
        o_bytes_due  <= scaled_bytes_due.size();
        o_mismatches <= mismatches;
    end

endmodule

FILE: tb/tb_glyph_bitmap_scaler_core.sv
// ----------------------------------------------------------------------------
// tb_glyph_bitmap_scaler_core
// Drives pixel-byte requests into the glyph bitmap scaler under every scale
// operation and merge mode, with random gaps on the sender and random stalls
// on the receiver. A checker beside the block predicts and compares each
// scaled byte; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_glyph_bitmap_scaler_core
    import gbs_pkg::*;
();

    // Longest request: double height replay of a full-width row, plus margin
    localparam int unsigned SETTLE_CYCLES   = 3 + 2 * GBS_MAX_ROW_BYTES + 13;
    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam int unsigned RANDOM_REQUESTS = 220;

    // Scale operation code with no function: bytes are consumed, nothing leaves
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Merge modes when halving: the two ink codes act alike, as do the space codes
    localparam logic [1:0] RM_INK       = 2'd0;
    localparam logic [1:0] RM_INK_ALT   = 2'd1;
    localparam logic [1:0] RM_SPACE     = 2'd2;
    localparam logic [1:0] RM_SPACE_ALT = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_pixel_byte;
    logic [7:0]            i_ink_width;
    logic [7:0]            i_glyph_rows;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_glyph_end;

    int          bytes_due;
    int          mismatches;
    int unsigned cycle_count    = 0;
    int unsigned pixel_requests = 0;
    bit          tx_quiet       = 1'b0;
    bit          rx_quiet       = 1'b0;
    int unsigned rx_hold        = 0;
    int unsigned rx_draw;

    always #10 i_clk = ~i_clk;

    glyph_bitmap_scaler_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel_byte (i_pixel_byte),
        .i_ink_width  (i_ink_width),
        .i_glyph_rows (i_glyph_rows),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_glyph_end  (o_glyph_end)
    );

    gbs_output_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_pixel_byte (i_pixel_byte),
        .i_ink_width  (i_ink_width),
        .i_glyph_rows (i_glyph_rows),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_byte   (o_out_byte),
        .i_glyph_end  (o_glyph_end),
        .o_bytes_due  (bytes_due),
        .o_mismatches (mismatches)
    );

    // Watchdog: stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL glyph_bitmap_scaler_core");
            $finish;
        end
    end

    // Receiver: after each delivered byte, draw a random stall.
    // Now and then flip into a quiet stretch where ready stays high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_hold     <= 0;
        end else if (i_out_ready) begin
            if (o_out_valid) begin
                if ($urandom_range(0, 39) == 0) rx_quiet <= !rx_quiet;
                rx_draw = rx_quiet ? 0 : $urandom_range(0, 6);
                if (rx_draw != 0) begin
                    i_out_ready <= 1'b0;
                    rx_hold     <= rx_draw - 1;
                end
            end
        end else if (rx_hold == 0) begin
            i_out_ready <= 1'b1;
        end else begin
            rx_hold <= rx_hold - 1;
        end
    end

    function automatic logic [7:0] draw_pixels();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Send one request: idle for a drawn gap, raise valid with the payload,
    // hold it until the block accepts. Valid stays high for a back-to-back
    // request so it is never dropped and raised in the same step.
    task automatic send_request(input logic [7:0] px, input logic [7:0] ink,
                                input logic [7:0] rows);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pixel_byte <= px;
        i_ink_width  <= ink;
        i_glyph_rows <= rows;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (ink != 8'd0 && rows != 8'd0) pixel_requests++;
    endtask

    // Empty glyph request: zero width or zero height, returns the block to
    // the start of a glyph
    task automatic send_blank();
        if ($urandom_range(0, 1) == 0)
            send_request(draw_pixels(), 8'd0, 8'($urandom));
        else
            send_request(draw_pixels(), 8'($urandom), 8'd0);
    endtask

    // Send count pixel bytes of one glyph; with wobble, sizes jump mid-glyph
    task automatic send_glyph(input logic [7:0] ink, input logic [7:0] rows,
                              input int unsigned count, input bit wobble);
        logic [7:0] cur_ink, cur_rows;
        cur_ink  = ink;
        cur_rows = rows;
        for (int unsigned k = 0; k < count; k++) begin
            if (wobble && $urandom_range(0, 3) == 0) begin
                cur_ink  = 8'($urandom_range(1, 40));
                cur_rows = 8'($urandom_range(1, 4));
            end
            send_request(draw_pixels(), cur_ink, cur_rows);
        end
    endtask

    // Drop valid, wait until every predicted byte has been delivered, then
    // let the block finish any request that leaves nothing behind
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_due != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [1:0] op, input logic [1:0] mode);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SCALE_OP;
        i_cfg_data <= op;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_REDUCE_MODE;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [1:0]  op;
        logic [7:0]  ink, rows;
        int unsigned pick, kind, full;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_SCALE_OP;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_pixel_byte <= 8'h00;
        i_ink_width  <= 8'h00;
        i_glyph_rows <= 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Halve height, ink merge: single row passes through, then an odd
        // triple a,b,c gives a|b and b|c
        write_config(OP_HALVE_HEIGHT, RM_INK);
        send_request(8'hA5, 8'd8, 8'd1);
        send_request(8'hF0, 8'd8, 8'd3);
        send_request(8'h0F, 8'd8, 8'd3);
        send_request(8'h81, 8'd8, 8'd3);

        // Halve height, space merge, two bytes per row
        write_config(OP_HALVE_HEIGHT, RM_SPACE_ALT);
        send_glyph(8'd16, 8'd3, 6, 1'b0);

        // Double width: 12 pixels give an odd output byte count, so the
        // low half of the last byte of the row is dropped
        write_config(OP_DOUBLE_WIDTH, RM_INK_ALT);
        send_request(8'hFF, 8'd12, 8'd1);
        send_request(8'h00, 8'd12, 8'd1);
        // Widest and tallest sizes, cut short by an empty glyph
        send_request(8'hC3, 8'd255, 8'd255);
        send_request(8'h5A, 8'd255, 8'd255);
        send_request(8'h77, 8'd0, 8'd255);
        // Width shrinks mid-row: the position past the last byte counts as last
        send_request(8'h9E, 8'd24, 8'd2);
        send_request(8'h31, 8'd8, 8'd2);
        send_request(8'hE7, 8'd8, 8'd0);

        // Double height: each row emitted, then replayed from the store
        write_config(OP_DOUBLE_HEIGHT, RM_SPACE);
        send_glyph(8'd16, 8'd2, 4, 1'b0);

        // Unused operation: bytes consumed, nothing emitted
        write_config(OP_UNUSED, RM_INK);
        send_glyph(8'd8, 8'd2, 2, 1'b0);

        // Random phases: mostly complete glyphs with random content, some
        // empty-glyph noise and some glyphs cut short
        pixel_requests = 0;
        while (pixel_requests < RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 9);
            op = (pick == 0) ? OP_UNUSED :
                 (pick < 4)  ? OP_HALVE_HEIGHT :
                 (pick < 7)  ? OP_DOUBLE_WIDTH : OP_DOUBLE_HEIGHT;
            write_config(op, 2'($urandom_range(0, 3)));
            repeat ($urandom_range(2, 6)) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                // keep most glyphs small; a few use the widest rows
                if ($urandom_range(0, 11) == 0) begin
                    ink  = 8'($urandom_range(200, 255));
                    rows = 8'($urandom_range(1, 2));
                end else begin
                    ink  = 8'($urandom_range(1, 24));
                    rows = 8'($urandom_range(1, 6));
                end
                full = ((32'(ink) + 32'd7) >> 3) * 32'(rows);
                kind = $urandom_range(0, 11);
                case (kind)
                    0: send_blank();
                    1: begin
                        // tall glyph, abandoned after a few bytes
                        send_glyph(8'($urandom_range(1, 16)), 8'($urandom_range(128, 255)),
                                   $urandom_range(1, 6), 1'b0);
                        send_blank();
                    end
                    2: begin
                        send_glyph(ink, rows, $urandom_range(1, full), 1'b0);
                        send_blank();
                    end
                    3: begin
                        // Jump sizes only where no row store is read back;
                        // elsewhere it could read entries never written
                        if (op == OP_DOUBLE_WIDTH || op == OP_UNUSED) begin
                            send_glyph(ink, rows, $urandom_range(3, 10), 1'b1);
                            send_blank();
                        end else begin
                            send_glyph(ink, rows, full, 1'b0);
                        end
                    end
                    default: send_glyph(ink, rows, full, 1'b0);
                endcase
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("PASS glyph_bitmap_scaler_core");
        end else begin
            $display("FAIL glyph_bitmap_scaler_core");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/gbs_pkg.sv
sv/gbs_ctrl.sv
sv/gbs_dp.sv
sv/glyph_bitmap_scaler_core.sv
tb/gbs_output_checker.sv
tb/tb_glyph_bitmap_scaler_core.sv
